// ===== src/byte_framer_fletcher_checksum_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the byte framer.
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_FRAMER_FLETCHER_CHECKSUM_TOP_ASSERT_SVH
`define BYTE_FRAMER_FLETCHER_CHECKSUM_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFFC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BFFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

// ===== src/bffc_pkg.sv =====
// ----------------------------------------------------------------------------
// bffc_pkg
// Shared types and constants of the byte framer with Fletcher checksum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bffc_pkg;

  // Number of header bytes sent at the start of each frame (1 to 8).
  localparam int HEADER_COUNT = 4;

  // Largest number of results one input byte can cause.
  localparam int BURST_DEPTH = (HEADER_COUNT + 1 > 5) ? HEADER_COUNT + 1 : 5;
  localparam int PTR_W       = $clog2(BURST_DEPTH);
  localparam int CNT_W       = $clog2(BURST_DEPTH + 1);

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_PATTERN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERMINATOR_BYTE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_RATE       = 2'd2;

  localparam logic [8:0] IDLE_RATE_RESET = 9'd8;

  typedef struct packed {
    logic [63:0] header_pattern;
    logic [7:0]  terminator_byte;
    logic [8:0]  idle_rate;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       idle;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// ===== src/byte_framer_fletcher_checksum_top.sv =====
// ----------------------------------------------------------------------------
// byte_framer_fletcher_checksum_top
// Byte framer with header, Fletcher-16 checksum, terminator and idle groups.
// Each accepted byte's results are stored in the burst register and move on
// into the output register one result per cycle while the consumer keeps up;
// the input is held until the last of them moves on, and a byte that causes
// no result does not hold it at all.
// Reset (rst, synchronous, active high) clears framing state, sums, idle
// countdown and output valid, and loads the register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module byte_framer_fletcher_checksum_top (
  input  wire                           clk,
  input  wire                           rst,
  // Configuration write port: register 0 header_pattern, 1 terminator_byte,
  // 2 idle_rate. Other indexes are ignored.
  input  wire                           cfg_we,
  input  wire [bffc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [bffc_pkg::CFG_W-1:0]     cfg_data,
  // Input stream.
  input  wire                           s_tvalid,
  output logic                          s_tready,
  input  wire [7:0]                     s_tdata,   // [7:0] in_byte
  // Result stream.
  output logic                          m_tvalid,
  input  wire                           m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] out_byte
  output logic [0:0]                    m_tuser,   // [0] is_idle
  output logic                          m_tlast    // last_of_run
);

  bffc_pkg::cfg_t    cfg;
  bffc_pkg::result_t rd_entry;
  logic              rd_valid;
  logic              rd_ready;

  // Register bank; the user must write it only while the block is idle, as the block does not enforce this.
  bffc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The framer evaluates each accepted byte in one pass and stores every
  // result it causes in a burst register. A new transaction is taken when that
  // register is empty or as its last stored result moves into the output stage.
  bffc_framer u_framer (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_ready (s_tready),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry),
    .rd_ready (rd_ready)
  );

  // The output register decouples the two sides, so the framer can take
  // the next byte while the last result still waits for the consumer.
  bffc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .ld_valid (rd_valid),
    .ld_entry (rd_entry),
    .ld_ready (rd_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ===== src/bffc_cfg.sv =====
// ----------------------------------------------------------------------------
// bffc_cfg
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bffc_cfg (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire [bffc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [bffc_pkg::CFG_W-1:0]     cfg_data,
  output bffc_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_pattern  <= '0;
      cfg.terminator_byte <= '0;
      cfg.idle_rate       <= bffc_pkg::IDLE_RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bffc_pkg::REG_HEADER_PATTERN:  cfg.header_pattern  <= cfg_data;
        bffc_pkg::REG_TERMINATOR_BYTE: cfg.terminator_byte <= cfg_data[7:0];
        bffc_pkg::REG_IDLE_RATE:       cfg.idle_rate       <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/bffc_framer.sv =====
// ----------------------------------------------------------------------------
// bffc_framer
// Framing state, Fletcher sums and the burst register holding the results
// caused by one input byte, drained one result per cycle on rd_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "byte_framer_fletcher_checksum_top_assert.svh"

module bffc_framer (
  input  wire                 clk,
  input  wire                 rst,
  input  bffc_pkg::cfg_t      cfg,
  input  wire                 in_valid,
  input  wire [7:0]           in_byte,
  output logic                in_ready,
  output logic                rd_valid,
  output bffc_pkg::result_t   rd_entry,
  input  wire                 rd_ready
);

  logic       in_frame, in_frame_next;
  logic [7:0] payload_left, payload_left_next;
  logic [7:0] idle_countdown, idle_countdown_next;
  logic [7:0] sum_a, sum_a_next;
  logic [7:0] sum_b, sum_b_next;

  bffc_pkg::result_t                 burst [bffc_pkg::BURST_DEPTH];
  bffc_pkg::result_t                 burst_next [bffc_pkg::BURST_DEPTH];
  logic [bffc_pkg::CNT_W-1:0]        cnt, burst_len_next;
  logic [bffc_pkg::PTR_W-1:0]        ptr;

  logic       accept, drain;
  logic [8:0] rate_dec;
  logic [7:0] reload;
  logic [7:0] a_base, b_base;

  function automatic logic [7:0] add_mod255(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s >= 9'd255) ? 8'(s - 9'd255) : s[7:0];
  endfunction

  // A new byte is taken when the burst register is empty, or in the cycle
  // in which its last result moves on to the output stage.
  assign in_ready = (cnt == '0) || ((cnt == bffc_pkg::CNT_W'(1)) && rd_ready);
  assign accept   = in_valid && in_ready;
  assign rd_valid = (cnt != '0);
  assign drain    = rd_valid && rd_ready;
  assign rd_entry = burst[ptr];

  // Countdown reload: a rate of zero acts as one, and large rates saturate.
  assign rate_dec = cfg.idle_rate - 9'd1;
  assign reload   = (cfg.idle_rate == '0) ? 8'd0 :
                    (rate_dec[8] ? 8'hFF : rate_dec[7:0]);

  // A new frame restarts both sums from zero.
  assign a_base = in_frame ? sum_a : 8'd0;
  assign b_base = in_frame ? sum_b : 8'd0;

  always_comb begin
    in_frame_next       = in_frame;
    payload_left_next   = payload_left;
    idle_countdown_next = idle_countdown;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    burst_len_next      = '0;
    for (int i = 0; i < bffc_pkg::BURST_DEPTH; i++) begin
      burst_next[i] = '0;
    end

    if (!in_frame) begin
      if (in_byte == 8'd0) begin
        if (idle_countdown == 8'd0) begin
          idle_countdown_next = reload;
          burst_next[0]       = '{data: 8'd0, idle: 1'b1, last: 1'b1};
          burst_len_next      = bffc_pkg::CNT_W'(1);
        end else begin
          idle_countdown_next = idle_countdown - 8'd1;
        end
      end else begin
        in_frame_next       = 1'b1;
        idle_countdown_next = 8'd0;
        payload_left_next   = in_byte;
        sum_a_next          = add_mod255(a_base, in_byte);
        sum_b_next          = add_mod255(b_base, sum_a_next);
        for (int i = 0; i < bffc_pkg::HEADER_COUNT; i++) begin
          burst_next[i] = '{data: cfg.header_pattern[8*i +: 8], idle: 1'b0, last: 1'b0};
        end
        burst_next[bffc_pkg::HEADER_COUNT] = '{data: in_byte, idle: 1'b0, last: 1'b1};
        burst_len_next = bffc_pkg::CNT_W'(bffc_pkg::HEADER_COUNT + 1);
      end
    end else begin
      sum_a_next = add_mod255(a_base, in_byte);
      sum_b_next = add_mod255(b_base, sum_a_next);
      if (payload_left <= 8'd1) begin
        payload_left_next = 8'd0;
        in_frame_next     = 1'b0;
        burst_next[0]     = '{data: in_byte, idle: 1'b0, last: 1'b0};
        burst_next[1]     = '{data: sum_a_next, idle: 1'b0, last: 1'b0};
        burst_next[2]     = '{data: sum_b_next, idle: 1'b0, last: 1'b0};
        burst_next[3]     = '{data: cfg.terminator_byte, idle: 1'b0, last: 1'b0};
        burst_next[4]     = '{data: 8'd0, idle: 1'b1, last: 1'b1};
        burst_len_next    = bffc_pkg::CNT_W'(5);
      end else begin
        payload_left_next = payload_left - 8'd1;
        burst_next[0]     = '{data: in_byte, idle: 1'b0, last: 1'b1};
        burst_len_next    = bffc_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      payload_left   <= '0;
      idle_countdown <= '0;
      sum_a          <= '0;
      sum_b          <= '0;
      cnt            <= '0;
      ptr            <= '0;
    end else if (accept) begin
      in_frame       <= in_frame_next;
      payload_left   <= payload_left_next;
      idle_countdown <= idle_countdown_next;
      sum_a          <= sum_a_next;
      sum_b          <= sum_b_next;
      cnt            <= burst_len_next;
      ptr            <= '0;
    end else if (drain) begin
      cnt <= cnt - bffc_pkg::CNT_W'(1);
      ptr <= ptr + bffc_pkg::PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      burst <= burst_next;
    end
  end

  `BFFC_ASSERT_NEXT(a_burst_loaded, accept && (burst_len_next != '0), cnt == $past(burst_len_next))
  `BFFC_ASSERT_SAME(a_last_closes_burst, drain && (cnt == bffc_pkg::CNT_W'(1)), rd_entry.last)
  `BFFC_ASSERT_SAME(a_sums_reduced, 1'b1, (sum_a != 8'hFF) && (sum_b != 8'hFF))
  `BFFC_ASSERT_SAME(a_idle_payload, !in_frame, payload_left == 8'd0)
  `BFFC_ASSERT_SAME(a_frame_countdown, in_frame, idle_countdown == 8'd0)

endmodule

`default_nettype wire

// ===== src/bffc_out.sv =====
// ----------------------------------------------------------------------------
// bffc_out
// Output register stage of the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bffc_out (
  input  wire                clk,
  input  wire                rst,
  input  wire                ld_valid,
  input  bffc_pkg::result_t  ld_entry,
  output logic               ld_ready,
  output logic               m_tvalid,
  input  wire                m_tready,
  output logic [7:0]         m_tdata,
  output logic [0:0]         m_tuser,
  output logic               m_tlast
);

  assign ld_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ld_ready) begin
      m_tvalid <= ld_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_ready && ld_valid) begin
      m_tdata    <= ld_entry.data;
      m_tuser[0] <= ld_entry.idle;
      m_tlast    <= ld_entry.last;
    end
  end

endmodule

`default_nettype wire

// ===== test/byte_framer_fletcher_checksum_top_tb.sv =====
// ----------------------------------------------------------------------------
// Byte framer with Fletcher checksum: self-checking testbench
// Drives input bytes into the framer with random bursts and gaps, while the
// result side stalls on a rotating pattern or at random. An internal model of
// the framing, idle countdown and Fletcher sums predicts every result byte,
// and each accepted result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_framer_fletcher_checksum_top_tb;

  // An index past the end of the register list, which the block must ignore.
  localparam logic [bffc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 6;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PHASE_COUNT     = 5;
  localparam int ITEMS_PER_PHASE = 8;
  localparam int RUN_LIMIT_NS    = 5_000_000;

  typedef enum int {READY_ALWAYS, READY_PATTERN, READY_RANDOM} ready_mode_t;

  // Block ports. Every input holds a known value from time zero.
  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_we    = 1'b0;
  logic [bffc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bffc_pkg::CFG_W-1:0]     cfg_data  = '0;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata   = 8'h00;
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [7:0]                     m_tdata;
  logic [0:0]                     m_tuser;
  logic                           m_tlast;

  // Traffic shaping on both sides of the block.
  logic        sender_gaps = 1'b0;
  int          burst_left  = 0;
  ready_mode_t ready_mode  = READY_ALWAYS;
  logic [15:0] ready_pattern = 16'h0001;

  // The testbench's own copy of the registers and the framing state.
  logic [63:0] header_pattern;
  logic [7:0]  terminator_byte;
  logic [8:0]  idle_rate;
  logic        in_frame;
  logic [7:0]  payload_left;
  logic [7:0]  idle_countdown;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;

  // Line bytes predicted but not yet seen on the result stream, oldest first.
  bffc_pkg::result_t line_bytes_q[$];
  int                mismatch_count = 0;

  byte_framer_fletcher_checksum_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [7:0] in_byte
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [7:0] out_byte
    .m_tuser   (m_tuser),   // [0] is_idle
    .m_tlast   (m_tlast)    // last_of_run
  );

  always #CLK_HALF clk = ~clk;

  // The result side changes its ready at the falling edge. In pattern mode
  // the pattern rotates one place per cycle; it always holds at least one set
  // bit, so every stall comes to an end.
  always @(negedge clk) begin
    case (ready_mode)
      READY_ALWAYS: begin
        m_tready <= 1'b1;
      end
      READY_PATTERN: begin
        m_tready      <= ready_pattern[0];
        ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
      default: begin
        m_tready <= ($urandom_range(0, 2) != 0);
      end
    endcase
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic bffc_pkg::result_t line_byte(input logic [7:0] data, input logic idle);
    bffc_pkg::result_t r;
    r.data = data;
    r.idle = idle;
    r.last = 1'b0;
    return r;
  endfunction

  // One step of the Fletcher-16 sums, each kept in the range 0 to 254.
  task automatic fletcher_add(input logic [7:0] value);
    sum_a = 8'((int'(sum_a) + int'(value)) % 255);
    sum_b = 8'((int'(sum_b) + int'(sum_a)) % 255);
  endtask

  // Works out the line bytes that one accepted input byte causes and appends
  // them to the queue, with the last flag on the final one.
  task automatic predict_line_bytes(input logic [7:0] value);
    bffc_pkg::result_t burst[$];
    int                rate;
    if (!in_frame) begin
      if (value == 8'h00) begin
        // An idle flag emits a group only once the countdown has run out.
        if (idle_countdown == 8'h00) begin
          rate = (idle_rate == 9'd0) ? 1 : int'(idle_rate);
          idle_countdown = (rate - 1 > 255) ? 8'hFF : 8'(rate - 1);
          burst.push_back(line_byte(8'h00, 1'b1));
        end else begin
          idle_countdown--;
        end
      end else begin
        // A frame start clears the countdown, so the first idle flag after
        // the frame gives a group straight away.
        in_frame       = 1'b1;
        idle_countdown = 8'h00;
        for (int i = 0; i < bffc_pkg::HEADER_COUNT && i < 8; i++)
          burst.push_back(line_byte(header_pattern[8*i +: 8], 1'b0));
        burst.push_back(line_byte(value, 1'b0));
        payload_left = value;
        sum_a        = 8'h00;
        sum_b        = 8'h00;
        fletcher_add(value);
      end
    end else begin
      burst.push_back(line_byte(value, 1'b0));
      fletcher_add(value);
      if (payload_left <= 8'd1) begin
        payload_left = 8'h00;
        burst.push_back(line_byte(sum_a, 1'b0));
        burst.push_back(line_byte(sum_b, 1'b0));
        burst.push_back(line_byte(terminator_byte, 1'b0));
        burst.push_back(line_byte(8'h00, 1'b1));
        in_frame = 1'b0;
      end else begin
        payload_left--;
      end
    end
    if (burst.size() > 0)
      burst[burst.size() - 1].last = 1'b1;
    foreach (burst[k])
      line_bytes_q.push_back(burst[k]);
  endtask

  // Every result transaction is compared, field by field, with the oldest
  // prediction. A result predicted at its accepting edge must still pass the
  // output register, so pushes and pops in one step never touch the same entry.
  always @(posedge clk) begin : check_results
    bffc_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (line_bytes_q.size() == 0) begin
        report_mismatch($sformatf("result %02h idle %0d with nothing predicted",
                                  m_tdata, m_tuser[0]));
      end else begin
        want = line_bytes_q.pop_front();
        if (m_tdata !== want.data)
          report_mismatch($sformatf("out_byte %02h, predicted %02h", m_tdata, want.data));
        if (m_tuser[0] !== want.idle)
          report_mismatch($sformatf("is_idle %0b, predicted %0b", m_tuser[0], want.idle));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last_of_run %0b, predicted %0b", m_tlast, want.last));
      end
    end
  end

  // Offers one input byte and waits for the transaction. With gaps enabled
  // the sender works in bursts and drops valid between them.
  // The task returns just after the accepting edge with valid still high, so
  // that a following call keeps the stream going without a bubble.
  task automatic send_byte(input logic [7:0] value);
    int gap_len;
    @(negedge clk);
    if (sender_gaps && burst_left == 0) begin
      gap_len    = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap_len) @(negedge clk);
    end
    if (burst_left > 0)
      burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    predict_line_bytes(value);
  endtask

  // Stops offering input and waits until every predicted result has come,
  // then waits out a drain margin for an idle flag that causes no result.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (line_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; only ever called while the block is idle.
  task automatic write_reg(input logic [bffc_pkg::CFG_IDX_W-1:0] index,
                           input logic [bffc_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      bffc_pkg::REG_HEADER_PATTERN:  header_pattern  = value;
      bffc_pkg::REG_TERMINATOR_BYTE: terminator_byte = value[7:0];
      bffc_pkg::REG_IDLE_RATE:       idle_rate       = value[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_traffic(input logic gaps, input ready_mode_t mode);
    sender_gaps   = gaps;
    burst_left    = 0;
    ready_mode    = mode;
    ready_pattern = 16'($urandom) | 16'h0001;
  endtask

  // A length byte followed by random payload. Where allowed, the sender now
  // and then holds off mid-frame until every predicted result has arrived.
  task automatic send_frame(input logic [7:0] len, input logic allow_pause);
    send_byte(len);
    for (int i = 0; i < int'(len); i++) begin
      if (allow_pause && $urandom_range(0, 49) == 0)
        wait_idle();
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Register reset values: the first idle flag gives a group, the next seven
  // are counted off silently, and a frame in between clears the countdown.
  task automatic test_reset_defaults();
    set_traffic(1'b0, READY_ALWAYS);
    repeat (9) send_byte(8'h00);
    repeat (2) send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h00);
    wait_idle();
  endtask

  // Extreme register values, with stray high bits in the write data that the
  // block must drop, a write to an index past the list, and an idle rate of
  // zero, which behaves as a rate of one.
  task automatic test_register_extremes();
    set_traffic(1'b1, READY_PATTERN);
    write_reg(bffc_pkg::REG_HEADER_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(bffc_pkg::REG_TERMINATOR_BYTE, 64'hABCD_EF01_2345_67FF);
    write_reg(bffc_pkg::REG_IDLE_RATE, 64'hFFFF_FFFF_FFFF_FE01);
    write_reg(REG_UNUSED, 64'h5A5A_5A5A_5A5A_5A5A);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_idle();
    write_reg(bffc_pkg::REG_HEADER_PATTERN, 64'h0000_0000_0000_0000);
    write_reg(bffc_pkg::REG_TERMINATOR_BYTE, 64'hFFFF_FFFF_FFFF_FF00);
    write_reg(bffc_pkg::REG_IDLE_RATE, 64'hFFFF_FFFF_FFFF_FE00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h03);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h7F);
    wait_idle();
  endtask

  // Idle rates above 256: the reloaded countdown stops at 255 rather than
  // wrapping to a small value, so the flags after the first give no group.
  // A short frame clears the countdown between the two rates.
  task automatic test_idle_rate_limits();
    set_traffic(1'b1, READY_RANDOM);
    write_reg(bffc_pkg::REG_IDLE_RATE, 64'd257);
    repeat (3) send_byte(8'h00);
    wait_idle();
    write_reg(bffc_pkg::REG_IDLE_RATE, 64'd511);
    send_frame(8'h01, 1'b0);
    repeat (3) send_byte(8'h00);
    wait_idle();
  endtask

  // One long frame whose length has the top bit set, so that the payload
  // count uses all eight bits and both sums wrap many times.
  task automatic test_long_frame();
    set_traffic(1'b1, READY_PATTERN);
    write_reg(bffc_pkg::REG_HEADER_PATTERN, {$urandom, $urandom});
    write_reg(bffc_pkg::REG_TERMINATOR_BYTE, 64'($urandom));
    write_reg(bffc_pkg::REG_IDLE_RATE, 64'd4);
    send_frame(8'h80, 1'b0);
    send_byte(8'h00);
    wait_idle();
  endtask

  // Random traffic in phases, each with its own register settings and
  // handshake behaviour. Most of it is well-formed frames with random
  // content; the rest is runs of idle flags. The first phase runs with no
  // idling on either side.
  task automatic test_random_traffic();
    int          phase_items;
    int          choice;
    int          len;
    int          run;
    logic [63:0] rate;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_idle();
      case (phase)
        0:       rate = 64'd1;
        1:       rate = 64'd2;
        2:       rate = 64'($urandom_range(3, 12));
        3:       rate = 64'd0;
        default: rate = 64'($urandom_range(13, 40));
      endcase
      write_reg(bffc_pkg::REG_HEADER_PATTERN, {$urandom, $urandom});
      write_reg(bffc_pkg::REG_TERMINATOR_BYTE, 64'($urandom));
      write_reg(bffc_pkg::REG_IDLE_RATE, rate);
      case (phase % 3)
        0:       set_traffic(phase != 0, (phase == 0) ? READY_ALWAYS : READY_RANDOM);
        1:       set_traffic(1'b1, READY_PATTERN);
        default: set_traffic(1'b1, READY_RANDOM);
      endcase
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        choice = $urandom_range(0, 99);
        if (choice < 65) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
          send_frame(8'(len), 1'b1);
          phase_items += len + 1;
        end else begin
          run = $urandom_range(1, 12);
          repeat (run) send_byte(8'h00);
          phase_items += run;
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    header_pattern  = 64'h0;
    terminator_byte = 8'h00;
    idle_rate       = bffc_pkg::IDLE_RATE_RESET;
    in_frame        = 1'b0;
    payload_left    = 8'h00;
    idle_countdown  = 8'h00;
    sum_a           = 8'h00;
    sum_b           = 8'h00;

    // Synchronous reset, held from time zero and released at a falling
    // edge so that the block leaves reset cleanly at the next rising edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_extremes();
    test_idle_rate_limits();
    test_long_frame();
    test_random_traffic();

    if (line_bytes_q.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", line_bytes_q.size()));

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Safety net: the slowest correct run takes well under a tenth of this.
  initial begin
    #RUN_LIMIT_NS;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/bffc_pkg.sv
src/bffc_cfg.sv
src/bffc_framer.sv
src/bffc_out.sv
src/byte_framer_fletcher_checksum_top.sv
test/byte_framer_fletcher_checksum_top_tb.sv
